// ===== rtl/jsv_pkg.sv =====
// shared types, codes and helpers for the json syntax validator
package jsv_pkg;

  localparam int unsigned StackDepthDef = 256;
  localparam int unsigned OffsetBitsDef = 32;
  localparam int unsigned NestBits = 9;

  // status codes
  localparam logic [3:0] ST_OK     = 4'd0;
  localparam logic [3:0] ST_UTF8   = 4'd1;
  localparam logic [3:0] ST_CTRL   = 4'd2;
  localparam logic [3:0] ST_ESCEND = 4'd3;
  localparam logic [3:0] ST_HEXESC = 4'd4;
  localparam logic [3:0] ST_ESCAPE = 4'd5;
  localparam logic [3:0] ST_UNTERM = 4'd6;
  localparam logic [3:0] ST_KEY    = 4'd7;
  localparam logic [3:0] ST_COLON  = 4'd8;
  localparam logic [3:0] ST_COMMA  = 4'd9;
  localparam logic [3:0] ST_DIGIT  = 4'd10;
  localparam logic [3:0] ST_VALUE  = 4'd11;
  localparam logic [3:0] ST_DEPTH  = 4'd12;
  localparam logic [3:0] ST_TRAIL  = 4'd13;

  // literal spelling table, index 0..12
  function automatic logic [7:0] lit_char(input logic [3:0] i);
    case (i)
      4'd0: lit_char = "t";  4'd1: lit_char = "r";  4'd2: lit_char = "u";
      4'd3: lit_char = "e";  4'd4: lit_char = "f";  4'd5: lit_char = "a";
      4'd6: lit_char = "l";  4'd7: lit_char = "s";  4'd8: lit_char = "e";
      4'd9: lit_char = "n";  4'd10: lit_char = "u"; 4'd11: lit_char = "l";
      4'd12: lit_char = "l";
      default: lit_char = 8'h00;
    endcase
  endfunction

  function automatic logic lit_end(input logic [3:0] i);
    lit_end = (i == 4'd3) || (i == 4'd8) || (i == 4'd12);
  endfunction

endpackage

// ===== rtl/jsv_utf8.sv =====
// strict utf-8 sequence checker, first fault kept
module jsv_utf8 import jsv_pkg::*; #(
  parameter int unsigned OffsetBits = OffsetBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  beat_i,
  input  logic                  last_i,
  input  logic [7:0]            byte_i,
  input  logic [OffsetBits-1:0] pos_i,
  output logic                  fault_o,
  output logic [OffsetBits-1:0] fault_at_o
);

  logic [1:0]            pend_q, pend_d;
  logic [20:0]           part_q, part_d;
  logic [1:0]            cls_q, cls_d;
  logic [OffsetBits-1:0] start_q, start_d;
  logic                  seen_q, seen_d;
  logic [OffsetBits-1:0] at_q, at_d;
  logic [20:0]           acc;
  logic [20:0]           minimum;

  // next state of the decoder
  always_comb begin
    pend_d = pend_q; part_d = part_q; cls_d = cls_q; start_d = start_q;
    seen_d = seen_q; at_d = at_q;
    acc = {part_q[14:0], byte_i[5:0]};
    case (cls_q)
      2'd1: minimum = 21'h80;
      2'd2: minimum = 21'h800;
      default: minimum = 21'h10000;
    endcase
    fault_o = seen_q;
    fault_at_o = at_q;
    if (!seen_q) begin
      if (pend_q == 2'd0) begin
        if (byte_i[7]) begin
          start_d = pos_i;
          if (byte_i >= 8'hc2 && byte_i <= 8'hdf) begin
            pend_d = 2'd1; part_d = {16'd0, byte_i[4:0]}; cls_d = 2'd1;
          end else if (byte_i >= 8'he0 && byte_i <= 8'hef) begin
            pend_d = 2'd2; part_d = {17'd0, byte_i[3:0]}; cls_d = 2'd2;
          end else if (byte_i >= 8'hf0 && byte_i <= 8'hf4) begin
            pend_d = 2'd3; part_d = {18'd0, byte_i[2:0]}; cls_d = 2'd3;
          end else begin
            seen_d = 1'b1; at_d = pos_i; pend_d = 2'd0;
          end
        end
      end else if (byte_i[7:6] != 2'b10) begin
        seen_d = 1'b1; at_d = start_q; pend_d = 2'd0;
      end else begin
        part_d = acc;
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1 && (acc < minimum || acc > 21'h10ffff ||
            (acc >= 21'hd800 && acc <= 21'hdfff))) begin
          seen_d = 1'b1; at_d = start_q; pend_d = 2'd0;
        end
      end
      // truncated at end of document
      if (!seen_d && pend_d != 2'd0) begin
        fault_o = last_i;
        fault_at_o = start_q;
        if (pend_q == 2'd0) fault_at_o = pos_i;
      end else begin
        fault_o = seen_d;
        fault_at_o = at_d;
      end
    end
  end

  // decoder registers, cleared at end of each document
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0; part_q <= '0; cls_q <= '0; start_q <= '0;
      seen_q <= 1'b0; at_q <= '0;
    end else if (beat_i) begin
      if (last_i) begin
        pend_q <= '0; part_q <= '0; cls_q <= '0; start_q <= '0;
        seen_q <= 1'b0; at_q <= '0;
      end else begin
        pend_q <= pend_d; part_q <= part_d; cls_q <= cls_d; start_q <= start_d;
        seen_q <= seen_d; at_q <= at_d;
      end
    end
  end

`ifndef SYNTH
  a_pend_clear_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> pend_q == 2'd0) else $error("utf8 pending with fault");
  a_cls_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd0 |-> cls_q >= pend_q) else $error("utf8 class below pending");
  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && last_i |=> !seen_q && pend_q == 2'd0) else $error("utf8 not cleared");
`endif

endmodule

// ===== rtl/json_syntax_validator.sv =====
// top level: streaming json syntax and utf-8 validator
//
//  channel   dir  handshake            payload
//  s_axis    in   s_axis_tvalid/ready  tdata byte_value, tlast last_byte
//  m_axis    out  m_axis_tvalid/ready  tdata status, fault_offset
//  cfg       in   cfg_we_i             cfg_wdata_i max_nesting
//
// one byte per cycle; grammar and utf-8 checks, fed by the registered stack top
// copies, are combinational in front of a registered result stage, so a result
// is valid the cycle after its last byte is accepted. s_axis_tready drops while
// a result waits untaken; a result taken in the same cycle lets the next beat in.
// reset clears all document state; the stack needs no clear since a push
// always writes an entry before it is read.
module json_syntax_validator import jsv_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDef,
  parameter int unsigned OffsetBits = OffsetBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] status, [35:4] fault_offset, [39:36] zero
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);

  localparam int unsigned SB = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned NW = ($clog2(StackDepth + 1) > NestBits) ?
                               $clog2(StackDepth + 1) : NestBits + 1;
  localparam logic [OffsetBits-1:0] OffMax = '1;

  localparam logic [4:0] M_VALUE = 5'd0,  M_ARR_FIRST = 5'd1, M_OBJ_FIRST = 5'd2,
    M_KEY = 5'd3, M_COLON = 5'd4, M_AFTER = 5'd5, M_STR = 5'd6, M_STR_ESC = 5'd7,
    M_STR_HEX = 5'd8, M_KSTR = 5'd9, M_KSTR_ESC = 5'd10, M_KSTR_HEX = 5'd11,
    M_NUM_SIGN = 5'd12, M_NUM_ZERO = 5'd13, M_NUM_INT = 5'd14, M_NUM_DOT = 5'd15,
    M_NUM_FRAC = 5'd16, M_NUM_EXP = 5'd17, M_NUM_EXP_SIGN = 5'd18,
    M_NUM_EXP_DIG = 5'd19, M_LIT = 5'd20, M_DONE = 5'd21;

  logic                  beat;
  logic [8:0]            maxn_q;
  logic [4:0]            mode_q, mode_d;
  logic [NW-1:0]         nest_q, nest_d;
  logic [OffsetBits-1:0] pos_q, pos_inc;
  logic [3:0]            code_q, code_d;
  logic [OffsetBits-1:0] sat_q, sat_d;
  logic [3:0]            lit_q, lit_d;
  logic [OffsetBits-1:0] lstart_q, lstart_d;
  logic [2:0]            hex_q, hex_d;
  logic                  stk [StackDepth];
  logic                  top_q;       // copy of stack top
  logic                  push, pop;
  logic                  push_val;
  logic [SB-1:0]         push_idx;
  logic                  below_q;     // entry under top, for pop refresh
  logic                  utf_fault;
  logic [OffsetBits-1:0] utf_at;
  logic                  oval_q;
  logic [3:0]            ost_q, ost_d;
  logic [31:0]           ooff_q, ooff_d;
  logic [NW-1:0]         limit;
  logic [7:0]            b;
  logic                  ws, dig, hexd;
  logic [4:0]            m;
  logic [OffsetBits-1:0] fat;

  assign b = s_axis_tdata;
  assign s_axis_tready = !oval_q || m_axis_tready;
  assign beat = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata = {4'd0, ooff_q, ost_q};
  assign pos_inc = (pos_q == OffMax) ? pos_q : pos_q + 1'b1;
  assign ws = b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d;
  assign dig = b >= "0" && b <= "9";
  assign hexd = dig || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");

  always_comb begin
    limit = NW'(maxn_q);
    if (limit > NW'(StackDepth)) limit = NW'(StackDepth);
  end

  jsv_utf8 #(.OffsetBits(OffsetBits)) u_utf8 (
    .clk_i, .rst_ni, .beat_i(beat), .last_i(s_axis_tlast), .byte_i(b),
    .pos_i(pos_q), .fault_o(utf_fault), .fault_at_o(utf_at)
  );

  // grammar automaton, number modes may fall through to after-value
  always_comb begin
    mode_d = mode_q; nest_d = nest_q; code_d = code_q; sat_d = sat_q;
    lit_d = lit_q; lstart_d = lstart_q; hex_d = hex_q;
    push = 1'b0; pop = 1'b0; push_val = (b == "{");
    push_idx = nest_q[SB-1:0];
    m = mode_q;
    if (code_q == ST_OK) begin
      if (m == M_ARR_FIRST && !ws && b != "]") m = M_VALUE;
      if ((m == M_NUM_ZERO || m == M_NUM_INT || m == M_NUM_FRAC || m == M_NUM_EXP_DIG)
          && !(dig && m != M_NUM_ZERO)
          && !(b == "." && (m == M_NUM_ZERO || m == M_NUM_INT))
          && !((b == "e" || b == "E") && m != M_NUM_EXP_DIG)) m = M_AFTER;
      case (m)
        M_ARR_FIRST: if (b == "]") begin pop = 1'b1; mode_d = M_AFTER; end
        M_VALUE: if (!ws) begin
          mode_d = m;
          if (b == "\"") mode_d = M_STR;
          else if (b == "{" || b == "[") begin
            if (nest_q >= limit) begin code_d = ST_DEPTH; sat_d = pos_q; end
            else begin
              push = 1'b1;
              mode_d = (b == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
            end
          end else if (b == "-") mode_d = M_NUM_SIGN;
          else if (b == "0") mode_d = M_NUM_ZERO;
          else if (dig) mode_d = M_NUM_INT;
          else if (b == "t" || b == "f" || b == "n") begin
            lstart_d = pos_q; mode_d = M_LIT;
            lit_d = (b == "t") ? 4'd1 : (b == "f") ? 4'd5 : 4'd10;
          end else begin code_d = ST_VALUE; sat_d = pos_q; end
        end
        M_OBJ_FIRST, M_KEY: if (!ws) begin
          if (m == M_OBJ_FIRST && b == "}") begin pop = 1'b1; mode_d = M_AFTER; end
          else if (b == "\"") mode_d = M_KSTR;
          else begin code_d = ST_KEY; sat_d = pos_q; end
        end
        M_COLON: if (!ws) begin
          if (b == ":") mode_d = M_VALUE;
          else begin code_d = ST_COLON; sat_d = pos_q; end
        end
        M_AFTER: begin
          mode_d = M_AFTER;
          if (!ws) begin
            if (nest_q == '0) begin code_d = ST_TRAIL; sat_d = pos_q; end
            else if (b == (top_q ? 8'h7d : 8'h5d)) pop = 1'b1;
            else if (b == ",") mode_d = top_q ? M_KEY : M_VALUE;
            else begin code_d = ST_COMMA; sat_d = pos_q; end
          end
        end
        M_STR, M_KSTR: begin
          if (b == "\"") mode_d = (m == M_KSTR) ? M_COLON : M_AFTER;
          else if (b < 8'd32) begin code_d = ST_CTRL; sat_d = pos_inc; end
          else if (b == "\\") mode_d = m + 5'd1;
        end
        M_STR_ESC, M_KSTR_ESC: begin
          if (b == "u") begin hex_d = '0; mode_d = m + 5'd1; end
          else if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
                   b == "n" || b == "r" || b == "t") mode_d = m - 5'd1;
          else begin code_d = ST_ESCAPE; sat_d = pos_inc; end
        end
        M_STR_HEX, M_KSTR_HEX: begin
          if (!hexd) begin code_d = ST_HEXESC; sat_d = pos_q; end
          else begin
            hex_d = hex_q + 3'd1;
            if (hex_q == 3'd3) mode_d = m - 5'd2;
          end
        end
        M_NUM_SIGN: begin
          if (b == "0") mode_d = M_NUM_ZERO;
          else if (dig) mode_d = M_NUM_INT;
          else begin code_d = ST_DIGIT; sat_d = pos_q; end
        end
        M_NUM_DOT, M_NUM_EXP_SIGN: begin
          if (dig) mode_d = (m == M_NUM_DOT) ? M_NUM_FRAC : M_NUM_EXP_DIG;
          else begin code_d = ST_DIGIT; sat_d = pos_q; end
        end
        M_NUM_EXP: begin
          if (b == "+" || b == "-") mode_d = M_NUM_EXP_SIGN;
          else if (dig) mode_d = M_NUM_EXP_DIG;
          else begin code_d = ST_DIGIT; sat_d = pos_q; end
        end
        M_NUM_ZERO, M_NUM_INT, M_NUM_FRAC, M_NUM_EXP_DIG: begin
          if (b == ".") mode_d = M_NUM_DOT;
          else if (b == "e" || b == "E") mode_d = M_NUM_EXP;
        end
        M_LIT: begin
          if (lit_q < 4'd13 && b == lit_char(lit_q)) begin
            if (lit_end(lit_q)) mode_d = M_AFTER;
            else lit_d = lit_q + 4'd1;
          end else begin code_d = ST_VALUE; sat_d = lstart_q; end
        end
        default: ;
      endcase
      if (push) nest_d = nest_q + 1'b1;
      if (pop && nest_q != '0) nest_d = nest_q - 1'b1;
      if (code_d != ST_OK) mode_d = M_DONE;
    end
    // end-of-document check
    ost_d = code_d; fat = sat_d;
    if (code_d == ST_OK) begin
      case (mode_d)
        M_VALUE, M_ARR_FIRST: begin ost_d = ST_VALUE; fat = pos_inc; end
        M_OBJ_FIRST, M_KEY: begin ost_d = ST_KEY; fat = pos_inc; end
        M_COLON: begin ost_d = ST_COLON; fat = pos_inc; end
        M_STR, M_KSTR: begin ost_d = ST_UNTERM; fat = pos_inc; end
        M_STR_ESC, M_KSTR_ESC: begin ost_d = ST_ESCEND; fat = pos_inc; end
        M_STR_HEX, M_KSTR_HEX: begin ost_d = ST_HEXESC; fat = pos_inc; end
        M_NUM_SIGN, M_NUM_DOT, M_NUM_EXP, M_NUM_EXP_SIGN: begin
          ost_d = ST_DIGIT; fat = pos_inc;
        end
        M_LIT: begin ost_d = ST_VALUE; fat = lstart_d; end
        default: if (nest_d != '0) begin ost_d = ST_COMMA; fat = pos_inc; end
      endcase
    end
    if (utf_fault) begin ost_d = ST_UTF8; fat = utf_at; end
    if (ost_d == ST_OK) ooff_d = '0;
    else if (OffsetBits > 32 && (fat >> 32) != '0) ooff_d = '1;
    else ooff_d = 32'(fat);
  end

  // container stack with registered top and next-below copies
  always_ff @(posedge clk_i) begin
    if (beat && push) stk[push_idx] <= push_val;
  end
  always_ff @(posedge clk_i) begin
    if (beat) begin
      if (push) begin
        top_q <= push_val;
        below_q <= top_q;
      end else if (pop) begin
        top_q <= below_q;
        below_q <= (nest_q >= NW'(3)) ? stk[SB'(nest_q - NW'(3))] : 1'b0;
      end
    end
  end

  // document and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxn_q <= 9'd256; mode_q <= M_VALUE; nest_q <= '0; pos_q <= '0;
      code_q <= ST_OK; sat_q <= '0; lit_q <= '0; lstart_q <= '0; hex_q <= '0;
      oval_q <= 1'b0; ost_q <= ST_OK; ooff_q <= '0;
    end else begin
      if (cfg_we_i) maxn_q <= cfg_wdata_i;
      if (oval_q && m_axis_tready && !(beat && s_axis_tlast)) oval_q <= 1'b0;
      if (beat) begin
        if (s_axis_tlast) begin
          mode_q <= M_VALUE; nest_q <= '0; pos_q <= '0; code_q <= ST_OK;
          sat_q <= '0; lit_q <= '0; lstart_q <= '0; hex_q <= '0;
          oval_q <= 1'b1; ost_q <= ost_d; ooff_q <= ooff_d;
        end else begin
          mode_q <= mode_d; nest_q <= nest_d; pos_q <= pos_inc; code_q <= code_d;
          sat_q <= sat_d; lit_q <= lit_d; lstart_q <= lstart_d; hex_q <= hex_d;
        end
      end
    end
  end

`ifndef SYNTH
  a_nest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nest_q <= NW'(StackDepth)) else $error("nesting above stack");
  a_fault_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_q != ST_OK |-> mode_q == M_DONE) else $error("fault without done");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_ok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oval_q && ost_q == ST_OK |-> ooff_q == '0) else $error("ok with offset");
`endif

endmodule

// ===== dv/tb_json_syntax_validator.sv =====
// testbench for the streaming json syntax and utf-8 validator
module tb_json_syntax_validator;
  import jsv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // grammar states of the predictor
  typedef enum int {
    P_VALUE, P_ARR1, P_OBJ1, P_KEY, P_COLON, P_AFTER,
    P_STR, P_STR_ESC, P_STR_HEX, P_KSTR, P_KSTR_ESC, P_KSTR_HEX,
    P_NSIGN, P_NZERO, P_NINT, P_NDOT, P_NFRAC, P_NEXP, P_NEXPS, P_NEXPD,
    P_LIT, P_DONE
  } pmode_e;

  typedef struct packed {
    logic [31:0] offset;
    logic [3:0]  status;
  } verdict_t;

  // predicts one verdict per document and checks the returned beats
  class ValidatorScoreboard;
    bit [8:0] max_nest = 9'd256;
    verdict_t verdicts[$];
    int errors;
    pmode_e mode;
    bit stk[256];
    int nest;
    longint pos;
    int u_pend;
    bit [20:0] u_part;
    int u_minc;
    longint u_start;
    bit u_bad;
    longint u_at;
    logic [3:0] s_code;
    longint s_at;
    int litp;
    longint lit_at;
    int hexn;
    string spell = "truefalsenull";

    function new();
      clear_doc();
    endfunction

    function void clear_doc();
      mode = P_VALUE; nest = 0; pos = 0;
      u_pend = 0; u_part = 0; u_minc = 0; u_start = 0; u_bad = 0; u_at = 0;
      s_code = ST_OK; s_at = 0; litp = 0; lit_at = 0; hexn = 0;
    endfunction

    function void u_flag(longint at);
      u_bad = 1; u_at = at; u_pend = 0;
    endfunction

    // strict utf-8 decoder, first fault only
    function void utf8_step(bit [7:0] b);
      int minv;
      if (u_bad) return;
      if (u_pend == 0) begin
        if (b < 8'h80) return;
        u_start = pos;
        if (b >= 8'hC2 && b <= 8'hDF) begin
          u_pend = 1; u_part = 21'(b & 8'h1F); u_minc = 1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          u_pend = 2; u_part = 21'(b & 8'h0F); u_minc = 2;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          u_pend = 3; u_part = 21'(b & 8'h07); u_minc = 3;
        end else u_flag(pos);
        return;
      end
      if (b[7:6] != 2'b10) begin
        u_flag(u_start);
        return;
      end
      u_part = {u_part[14:0], b[5:0]};
      u_pend--;
      if (u_pend != 0) return;
      minv = (u_minc == 1) ? 'h80 : (u_minc == 2) ? 'h800 : 'h10000;
      if (u_part < minv || u_part > 21'h10FFFF || (u_part >= 'hD800 && u_part <= 'hDFFF))
        u_flag(u_start);
    endfunction

    function void fail(logic [3:0] c, longint at);
      s_code = c; s_at = at; mode = P_DONE;
    endfunction

    function bit is_ws(bit [7:0] b);
      return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D;
    endfunction

    function bit is_dig(bit [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function void close_cont();
      if (nest > 0) nest--;
      mode = P_AFTER;
    endfunction

    function void open_value(bit [7:0] b);
      int lim;
      lim = (max_nest > 256) ? 256 : max_nest;
      if (b == "\"") mode = P_STR;
      else if (b == "{" || b == "[") begin
        if (nest >= lim) fail(ST_DEPTH, pos);
        else begin
          stk[nest] = (b == "{");
          nest++;
          mode = (b == "{") ? P_OBJ1 : P_ARR1;
        end
      end else if (b == "-") mode = P_NSIGN;
      else if (b == "0") mode = P_NZERO;
      else if (is_dig(b)) mode = P_NINT;
      else if (b == "t" || b == "f" || b == "n") begin
        lit_at = pos;
        litp = (b == "t") ? 1 : (b == "f") ? 5 : 10;
        mode = P_LIT;
      end else fail(ST_VALUE, pos);
    endfunction

    // one grammar step; numbers and an array's first value may re-examine the byte
    function void grammar_step(bit [7:0] b);
      bit again;
      bit obj;
      do begin
        again = 0;
        case (mode)
          P_ARR1: begin
            if (is_ws(b)) ;
            else if (b == "]") close_cont();
            else begin
              mode = P_VALUE; again = 1;
            end
          end
          P_VALUE: if (!is_ws(b)) open_value(b);
          P_OBJ1, P_KEY: begin
            if (is_ws(b)) ;
            else if (mode == P_OBJ1 && b == "}") close_cont();
            else if (b == "\"") mode = P_KSTR;
            else fail(ST_KEY, pos);
          end
          P_COLON: begin
            if (is_ws(b)) ;
            else if (b == ":") mode = P_VALUE;
            else fail(ST_COLON, pos);
          end
          P_AFTER: begin
            if (is_ws(b)) ;
            else if (nest == 0) fail(ST_TRAIL, pos);
            else begin
              obj = stk[nest-1];
              if (b == (obj ? "}" : "]")) close_cont();
              else if (b == ",") mode = obj ? P_KEY : P_VALUE;
              else fail(ST_COMMA, pos);
            end
          end
          P_STR, P_KSTR: begin
            if (b == "\"") mode = (mode == P_KSTR) ? P_COLON : P_AFTER;
            else if (b < 32) fail(ST_CTRL, pos + 1);
            else if (b == "\\") mode = (mode == P_KSTR) ? P_KSTR_ESC : P_STR_ESC;
          end
          P_STR_ESC, P_KSTR_ESC: begin
            if (b == "u") begin
              hexn = 0;
              mode = (mode == P_KSTR_ESC) ? P_KSTR_HEX : P_STR_HEX;
            end else if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
                         b == "n" || b == "r" || b == "t")
              mode = (mode == P_KSTR_ESC) ? P_KSTR : P_STR;
            else fail(ST_ESCAPE, pos + 1);
          end
          P_STR_HEX, P_KSTR_HEX: begin
            if (!(is_dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F")))
              fail(ST_HEXESC, pos);
            else begin
              hexn++;
              if (hexn >= 4) mode = (mode == P_KSTR_HEX) ? P_KSTR : P_STR;
            end
          end
          P_NSIGN: begin
            if (b == "0") mode = P_NZERO;
            else if (is_dig(b)) mode = P_NINT;
            else fail(ST_DIGIT, pos);
          end
          P_NDOT, P_NEXPS: begin
            if (is_dig(b)) mode = (mode == P_NDOT) ? P_NFRAC : P_NEXPD;
            else fail(ST_DIGIT, pos);
          end
          P_NEXP: begin
            if (b == "+" || b == "-") mode = P_NEXPS;
            else if (is_dig(b)) mode = P_NEXPD;
            else fail(ST_DIGIT, pos);
          end
          P_NZERO, P_NINT, P_NFRAC, P_NEXPD: begin
            if (is_dig(b) && mode != P_NZERO) ;
            else if (b == "." && (mode == P_NZERO || mode == P_NINT)) mode = P_NDOT;
            else if ((b == "e" || b == "E") && mode != P_NEXPD) mode = P_NEXP;
            else begin
              mode = P_AFTER; again = 1;
            end
          end
          P_LIT: begin
            if (litp < 13 && b == spell[litp]) begin
              if (litp == 3 || litp == 8 || litp == 12) mode = P_AFTER;
              else litp++;
            end else fail(ST_VALUE, lit_at);
          end
          default: ;
        endcase
      end while (again);
    endfunction

    function void grammar_end();
      case (mode)
        P_VALUE, P_ARR1: fail(ST_VALUE, pos);
        P_OBJ1, P_KEY: fail(ST_KEY, pos);
        P_COLON: fail(ST_COLON, pos);
        P_STR, P_KSTR: fail(ST_UNTERM, pos);
        P_STR_ESC, P_KSTR_ESC: fail(ST_ESCEND, pos);
        P_STR_HEX, P_KSTR_HEX: fail(ST_HEXESC, pos);
        P_NSIGN, P_NDOT, P_NEXP, P_NEXPS: fail(ST_DIGIT, pos);
        P_LIT: fail(ST_VALUE, lit_at);
        P_NZERO, P_NINT, P_NFRAC, P_NEXPD, P_AFTER: if (nest != 0) fail(ST_COMMA, pos);
        default: ;
      endcase
    endfunction

    // accepted input beat
    function void note_byte(bit [7:0] b, bit last);
      verdict_t v;
      utf8_step(b);
      if (s_code == ST_OK) grammar_step(b);
      pos = (pos >= 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : pos + 1;
      if (!last) return;
      if (!u_bad && u_pend != 0) u_flag(u_start);
      if (s_code == ST_OK) grammar_end();
      if (u_bad) begin
        v.status = ST_UTF8; v.offset = 32'(u_at);
      end else if (s_code != ST_OK) begin
        v.status = s_code; v.offset = 32'(s_at);
      end else begin
        v.status = ST_OK; v.offset = 32'd0;
      end
      verdicts.push_back(v);
      clear_doc();
    endfunction

    // accepted output beat
    function void check_result(logic [39:0] data);
      verdict_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected result beat, actual status %0d offset %0d",
                 $realtime, data[3:0], data[35:4]);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (data[3:0] !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $realtime, want.status, data[3:0]);
        errors++;
      end
      if (data[35:4] !== want.offset) begin
        $display("%0t: offset mismatch, expected %0d actual %0d",
                 $realtime, want.offset, data[35:4]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = 9'd0;

  ValidatorScoreboard sb = new();
  int tx_idle = 23;
  int rx_idle = 67;
  bit hold_req = 0;
  int bytes_sent = 0;
  bit [7:0] doc[$];

  always #4 clk_i = ~clk_i;

  json_syntax_validator uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_wdata_i
  );

  // monitors sample pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // result side backpressure, with an occasional long hold-off
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  initial begin
    #3ms;
    $display("simulation failed");
    $finish;
  end

  // idle cycles come before the beat, each with the sender idle rate
  task automatic send_byte(bit [7:0] b, bit last);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // send the built document, last beat flagged
  task automatic send_doc();
    for (int i = 0; i < doc.size(); i++) send_byte(doc[i], i == doc.size() - 1);
  endtask

  task automatic send_text(string s);
    doc.delete();
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
    send_doc();
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.verdicts.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_nesting(bit [8:0] v);
    wait_drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.max_nest = v;
  endtask

  function automatic void add_ws();
    bit [7:0] ws[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
    while ($urandom_range(0, 3) == 0) doc.push_back(ws[$urandom_range(0, 3)]);
  endfunction

  // string body with escapes, hex escapes and multi-byte characters
  function automatic void add_string();
    string hexd = "0123456789abcdefABCDEF";
    string esc = "\"\\/bfnrt";
    doc.push_back("\"");
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0: begin
          doc.push_back("\\");
          doc.push_back(esc[$urandom_range(0, 7)]);
        end
        1: begin
          doc.push_back("\\"); doc.push_back("u");
          repeat (4) doc.push_back(hexd[$urandom_range(0, 21)]);
        end
        2: begin
          doc.push_back(8'(8'hC2 + $urandom_range(0, 29)));
          doc.push_back(8'(8'h80 + $urandom_range(0, 63)));
        end
        3: begin
          doc.push_back(8'(8'hE1 + $urandom_range(0, 11)));
          repeat (2) doc.push_back(8'(8'h80 + $urandom_range(0, 63)));
        end
        4: begin
          doc.push_back(8'(8'hF1 + $urandom_range(0, 2)));
          repeat (3) doc.push_back(8'(8'h80 + $urandom_range(0, 63)));
        end
        default: doc.push_back($urandom_range(32, 126) == 34 ? "a" : 8'($urandom_range(32, 126)));
      endcase
    end
    if (doc[doc.size()-1] == "\\") doc.push_back("n");
    doc.push_back("\"");
  endfunction

  function automatic void add_number();
    if ($urandom_range(0, 1)) doc.push_back("-");
    if ($urandom_range(0, 2) == 0) doc.push_back("0");
    else begin
      doc.push_back(8'("1" + $urandom_range(0, 8)));
      repeat ($urandom_range(0, 3)) doc.push_back(8'("0" + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 2) == 0) begin
      doc.push_back(".");
      repeat ($urandom_range(1, 3)) doc.push_back(8'("0" + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 3) == 0) begin
      doc.push_back($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: doc.push_back("+");
        1: doc.push_back("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) doc.push_back(8'("0" + $urandom_range(0, 9)));
    end
  endfunction

  function automatic void add_value(int depth);
    string lits[3] = '{"true", "false", "null"};
    string l;
    int n;
    int r;
    r = $urandom_range(0, 9);
    add_ws();
    if (depth > 0 && r < 4) begin
      n = $urandom_range(0, 3);
      doc.push_back(r < 2 ? "[" : "{");
      add_ws();
      for (int i = 0; i < n; i++) begin
        if (i > 0) doc.push_back(",");
        if (r >= 2) begin
          add_ws(); add_string(); add_ws(); doc.push_back(":");
        end
        add_value(depth - 1);
      end
      add_ws();
      doc.push_back(r < 2 ? "]" : "}");
    end else if (r < 6) add_string();
    else if (r < 8) add_number();
    else begin
      l = lits[$urandom_range(0, 2)];
      for (int i = 0; i < l.len(); i++) doc.push_back(l[i]);
    end
    add_ws();
  endfunction

  // mostly well-formed documents, some damaged or pure noise
  task automatic send_random_doc();
    int k;
    doc.delete();
    k = $urandom_range(0, 99);
    if (k < 8) repeat ($urandom_range(1, 12)) doc.push_back(8'($urandom_range(0, 255)));
    else begin
      add_value($urandom_range(0, 4));
      if (k < 20) doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
      else if (k < 27 && doc.size() > 1) doc = doc[0:$urandom_range(0, doc.size() - 2)];
      else if (k < 32) doc.push_back(8'($urandom_range(0, 255)));
    end
    send_doc();
  endtask

  initial begin
    bit [8:0] nest_vals[8] = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd5, 9'd256, 9'd511, 9'd4};
    string texts[$] = '{
      "0", "-", "-0.5e+10", "{\"a\":[true,false,null],\"b\":{}}", " [ ] ", "{}",
      "tru", "nulx", "[1,]", "{\"a\" 1}", "{1:2}", "\"\\x\"", "\"\\u12g4\"",
      "\"\\", "\"\\u12", "\"ab", "\"a\nb\"", "[1 2]", "1 2", "01", "-a", "1.",
      "1e", "1e+", "  ", "[\"\\u00e9\\/\",{\"k\":1E5}]"
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed documents at the reset nesting limit
    foreach (texts[i]) send_text(texts[i]);
    doc = '{8'h22, 8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h22}; send_doc();
    doc = '{8'h22, 8'hC0, 8'hAF, 8'h22}; send_doc();
    doc = '{8'h22, 8'hE0, 8'h80, 8'hAF, 8'h22}; send_doc();
    doc = '{8'h22, 8'hED, 8'hA0, 8'h80, 8'h22}; send_doc();
    doc = '{8'h22, 8'hF4, 8'h90, 8'h80, 8'h80, 8'h22}; send_doc();
    doc = '{8'h22, 8'hE2, 8'h82}; send_doc();
    doc = '{8'h5B, 8'hFF, 8'h00}; send_doc();
    doc = '{8'h22, 8'h00, 8'h22}; send_doc();
    // full nesting, then one level too deep
    doc.delete();
    repeat (256) doc.push_back("[");
    repeat (256) doc.push_back("]");
    send_doc();
    doc.delete();
    repeat (257) doc.push_back("[");
    send_doc();
    set_nesting(9'd0);
    send_text("[]");
    send_text("7");

    // random phases with changing idle rates and limits
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 23 : (ph == 1) ? 67 : 0;
      rx_idle = (ph == 0) ? 67 : (ph == 1) ? 23 : 0;
      bytes_sent = 0;
      while (bytes_sent < 220) begin
        if ($urandom_range(0, 24) == 0) begin
          if ($urandom_range(0, 1)) set_nesting(nest_vals[$urandom_range(0, 7)]);
          else set_nesting(9'($urandom_range(0, 511)));
        end
        send_random_doc();
      end
      if (ph == 1) begin
        // results held back while short documents keep coming
        wait_drain();
        hold_req = 1;
        repeat (20) send_text("1");
      end
    end

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
